>>> rtl/adaptive_majorant_grid_traversal_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the majorant grid traversal sequencer
// Implication forms with a common clock and active-low reset.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_MAJORANT_GRID_TRAVERSAL_ASSERT_SVH
`define ADAPTIVE_MAJORANT_GRID_TRAVERSAL_ASSERT_SVH

// same-cycle implication
`define AMGT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("amgt assertion failed");

// next-cycle implication
`define AMGT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("amgt assertion failed");

`endif

>>> rtl/amgt_pkg.sv
// ----------------------------------------------------------------------------
// amgt_pkg
// Shared types and constants of the majorant grid traversal block.
// ----------------------------------------------------------------------------
`default_nettype none

package amgt_pkg;

    localparam int COORD_W = 16;
    localparam int DATA_W  = 32;
    localparam int T_W     = 17;
    // plane index width, enough for the largest grid of sixteen
    localparam int KW      = 4;

    localparam logic [T_W-1:0]    ONE_Q16      = 17'h10000;
    localparam logic [DATA_W-1:0] MAJ_RESET    = 32'd655;
    localparam logic [DATA_W-1:0] MARGIN_RESET = 32'd13107;

    localparam logic KIND_UPDATE   = 1'b0;
    localparam logic KIND_TRAVERSE = 1'b1;

    // crossing walk of one axis
    typedef struct packed {
        logic          dir;   // 1 = planes ascending
        logic [KW-1:0] k;     // first plane
        logic [KW-1:0] cnt;   // planes to cross
    } t_axis;

    typedef struct packed {
        logic                            kind;
        logic [2:0][COORD_W-1:0]         pa;
        logic [2:0][COORD_W-1:0]         pb;
        logic [DATA_W-1:0]               r0;
        logic [DATA_W-1:0]               r1;
        logic [DATA_W-1:0]               dens;
        t_axis [2:0]                     ax;
    } t_item;

endpackage

`default_nettype wire

>>> rtl/amgt_front.sv
// ----------------------------------------------------------------------------
// amgt_front
// Input stage: takes items, works out the plane walk of each axis.
// ----------------------------------------------------------------------------
`default_nettype none

module amgt_front #(
    parameter int GRID_DIM = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_kind,
    input  wire logic [2:0][amgt_pkg::COORD_W-1:0] i_pa,
    input  wire logic [2:0][amgt_pkg::COORD_W-1:0] i_pb,
    input  wire logic [amgt_pkg::DATA_W-1:0]   i_r0,
    input  wire logic [amgt_pkg::DATA_W-1:0]   i_r1,
    input  wire logic [amgt_pkg::DATA_W-1:0]   i_dens,
    output logic                               o_valid,
    output amgt_pkg::t_item                    o_item,
    input  wire logic                          i_ready
);

    localparam int LG = $clog2(GRID_DIM);
    localparam int VW = amgt_pkg::COORD_W + LG;

    logic            r_valid;
    amgt_pkg::t_item r_item;
    amgt_pkg::t_item n_item;

    function automatic logic [LG-1:0] voxel(input logic [amgt_pkg::COORD_W-1:0] c);
        logic [VW-1:0] v;
        logic [LG-1:0] ix;
        v  = VW'(c) * VW'(GRID_DIM);
        ix = v[VW-1:amgt_pkg::COORD_W];
        if (ix > LG'(GRID_DIM - 1)) begin
            ix = LG'(GRID_DIM - 1);
        end
        return ix;
    endfunction

    // classify: direction, first plane and plane count per axis
    always_comb begin
        logic [LG-1:0] ia;
        logic [LG-1:0] ib;
        n_item      = '0;
        n_item.kind = i_kind;
        n_item.pa   = i_pa;
        n_item.pb   = i_pb;
        n_item.r0   = i_r0;
        n_item.r1   = i_r1;
        n_item.dens = i_dens;
        for (int ax = 0; ax < 3; ax++) begin
            ia = voxel(i_pa[ax]);
            ib = voxel(i_pb[ax]);
            if (ib > ia) begin
                n_item.ax[ax].dir = 1'b1;
                n_item.ax[ax].k   = amgt_pkg::KW'(ia) + 1'b1;
                n_item.ax[ax].cnt = amgt_pkg::KW'(ib - ia);
            end else if (ib < ia) begin
                n_item.ax[ax].dir = 1'b0;
                n_item.ax[ax].k   = amgt_pkg::KW'(ia);
                n_item.ax[ax].cnt = amgt_pkg::KW'(ia - ib);
            end else begin
                n_item.ax[ax].dir = 1'b0;
                n_item.ax[ax].k   = '0;
                n_item.ax[ax].cnt = '0;
            end
        end
    end

    assign o_ready = i_en && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

>>> rtl/amgt_queue.sv
// ----------------------------------------------------------------------------
// amgt_queue
// Two-entry queue between the input stage and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module amgt_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire amgt_pkg::t_item i_item,
    output logic                 o_valid,
    output amgt_pkg::t_item      o_item,
    input  wire logic            i_ready
);

    amgt_pkg::t_item r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

>>> rtl/amgt_div.sv
// ----------------------------------------------------------------------------
// amgt_div
// Restoring divider for crossing parameters, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module amgt_div #(
    parameter int VW = 20
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [VW-1:0]              i_num,
    input  wire logic [VW-1:0]              i_den,
    output logic                            o_done,
    output logic [amgt_pkg::T_W-1:0]        o_quot
);

    logic [VW:0]               r_rem;
    logic [VW-1:0]             r_den;
    logic [amgt_pkg::T_W-1:0]  r_quot;
    logic [4:0]                r_cnt;
    logic                      r_first;
    logic                      r_done;
    logic [VW:0]               w_trial;
    logic                      w_ge;

    // first step takes the integer bit without a shift
    assign w_trial = r_first ? r_rem : {r_rem[VW-1:0], 1'b0};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign o_done  = r_done;
    assign o_quot  = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= 5'(amgt_pkg::T_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= {1'b0, i_num};
            r_den   <= i_den;
            r_quot  <= '0;
            r_first <= 1'b1;
        end else if (r_cnt != '0) begin
            r_rem   <= w_ge ? (w_trial - {1'b0, r_den}) : w_trial;
            r_quot  <= {r_quot[amgt_pkg::T_W-2:0], w_ge};
            r_first <= 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> rtl/amgt_back.sv
// ----------------------------------------------------------------------------
// amgt_back
// Sequencer: grid memory, crossing merge, interpolation and piece output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adaptive_majorant_grid_traversal_assert.svh"

module amgt_back #(
    parameter int GRID_DIM = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [amgt_pkg::DATA_W-1:0]  i_margin,
    output logic                              o_ready_en,
    input  wire logic                         i_q_valid,
    output logic                              o_q_ready,
    input  wire amgt_pkg::t_item              i_q_item,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [amgt_pkg::COORD_W-1:0]      o_start_x,
    output logic [amgt_pkg::COORD_W-1:0]      o_start_y,
    output logic [amgt_pkg::COORD_W-1:0]      o_start_z,
    output logic [amgt_pkg::COORD_W-1:0]      o_end_x,
    output logic [amgt_pkg::COORD_W-1:0]      o_end_y,
    output logic [amgt_pkg::COORD_W-1:0]      o_end_z,
    output logic [amgt_pkg::DATA_W-1:0]       o_dist_start,
    output logic [amgt_pkg::DATA_W-1:0]       o_dist_end,
    output logic [amgt_pkg::DATA_W-1:0]       o_majorant,
    output logic                              o_last
);

    localparam int LG    = $clog2(GRID_DIM);
    localparam int VW    = amgt_pkg::COORD_W + LG;
    localparam int DEPTH = GRID_DIM * GRID_DIM * GRID_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = amgt_pkg::DATA_W + amgt_pkg::T_W;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_UPDA  = 4'd2;
    localparam logic [3:0] ST_UPDB  = 4'd3;
    localparam logic [3:0] ST_FILL  = 4'd4;
    localparam logic [3:0] ST_DIVW  = 4'd5;
    localparam logic [3:0] ST_PICK  = 4'd6;
    localparam logic [3:0] ST_LERP  = 4'd7;
    localparam logic [3:0] ST_MID   = 4'd8;
    localparam logic [3:0] ST_RDW   = 4'd9;
    localparam logic [3:0] ST_EMIT  = 4'd10;

    logic [3:0]                     r_state;
    logic [AW-1:0]                  r_clr;
    amgt_pkg::t_item                r_item;
    logic [amgt_pkg::KW-1:0]        r_k    [3];
    logic [amgt_pkg::KW-1:0]        r_cnt  [3];
    logic [amgt_pkg::T_W-1:0]       r_head [3];
    logic [1:0]                     r_ax;
    logic                           r_refill;
    logic [amgt_pkg::T_W-1:0]       r_t0;
    logic [amgt_pkg::T_W-1:0]       r_t1;
    logic [1:0]                     r_sel;
    logic                           r_last;
    logic [amgt_pkg::COORD_W-1:0]   r_p0 [3];
    logic [amgt_pkg::COORD_W-1:0]   r_p1 [3];
    logic [amgt_pkg::DATA_W-1:0]    r_d0;
    logic [amgt_pkg::DATA_W-1:0]    r_d1;
    logic [3:0]                     r_step;
    logic [PW-1:0]                  r_prod;
    logic [PW-1:0]                  r_acc;
    logic [AW-1:0]                  r_addr;
    logic [amgt_pkg::DATA_W-1:0]    r_rdata;
    logic [amgt_pkg::DATA_W-1:0]    r_grid [DEPTH];
    logic                           r_ovalid;

    function automatic logic [LG-1:0] voxel(input logic [amgt_pkg::COORD_W-1:0] c);
        logic [VW-1:0] v;
        logic [LG-1:0] ix;
        v  = VW'(c) * VW'(GRID_DIM);
        ix = v[VW-1:amgt_pkg::COORD_W];
        if (ix > LG'(GRID_DIM - 1)) begin
            ix = LG'(GRID_DIM - 1);
        end
        return ix;
    endfunction

    function automatic logic [AW-1:0] slot(input logic [amgt_pkg::COORD_W-1:0] x,
                                           input logic [amgt_pkg::COORD_W-1:0] y,
                                           input logic [amgt_pkg::COORD_W-1:0] z);
        return (AW'(voxel(z)) * AW'(GRID_DIM) + AW'(voxel(y))) * AW'(GRID_DIM)
               + AW'(voxel(x));
    endfunction

    // divider operands for the axis being filled or refilled
    logic                       w_div_start;
    logic [VW-1:0]              w_va;
    logic [VW-1:0]              w_vb;
    logic [VW-1:0]              w_kpos;
    logic [VW-1:0]              w_num;
    logic [VW-1:0]              w_den;
    logic                       w_div_done;
    logic [amgt_pkg::T_W-1:0]   w_quot;

    assign w_va   = VW'(r_item.pa[r_ax]) * VW'(GRID_DIM);
    assign w_vb   = VW'(r_item.pb[r_ax]) * VW'(GRID_DIM);
    assign w_kpos = VW'(r_k[r_ax]) << amgt_pkg::COORD_W;
    assign w_num  = r_item.ax[r_ax].dir ? (w_kpos - w_va) : (w_va - w_kpos);
    assign w_den  = r_item.ax[r_ax].dir ? (w_vb - w_va) : (w_va - w_vb);
    assign w_div_start = (r_state == ST_FILL) && (r_cnt[r_ax] != '0);

    amgt_div #(
        .VW (VW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // smallest of the three axis heads
    logic [amgt_pkg::T_W-1:0] w_min;
    logic [1:0]               w_min_ax;
    always_comb begin
        w_min    = r_head[0];
        w_min_ax = 2'd0;
        if (r_head[1] < w_min) begin
            w_min    = r_head[1];
            w_min_ax = 2'd1;
        end
        if (r_head[2] < w_min) begin
            w_min    = r_head[2];
            w_min_ax = 2'd2;
        end
    end

    // interpolation operand select: a then b per value, x y z then distance
    logic [1:0]                 w_lv;
    logic [amgt_pkg::DATA_W-1:0] w_op;
    logic [amgt_pkg::T_W-1:0]   w_tm;
    logic [1:0]                 w_pv;
    logic [PW-1:0]              w_sum;
    assign w_lv = r_step[2:1];
    always_comb begin
        if (w_lv == 2'd3) begin
            w_op = r_step[0] ? r_item.r1 : r_item.r0;
        end else begin
            w_op = amgt_pkg::DATA_W'(r_step[0] ? r_item.pb[w_lv] : r_item.pa[w_lv]);
        end
        w_tm = r_step[0] ? r_t1 : (amgt_pkg::ONE_Q16 - r_t1);
    end
    assign w_pv  = 2'((r_step - 4'd1) >> 1);
    assign w_sum = r_acc + r_prod;

    // midpoint of the current piece
    logic [amgt_pkg::COORD_W-1:0] w_mid [3];
    always_comb begin
        for (int ax = 0; ax < 3; ax++) begin
            w_mid[ax] = amgt_pkg::COORD_W'(({1'b0, r_p0[ax]} + {1'b0, r_p1[ax]}) >> 1);
        end
    end

    // majorant raise on update, saturating
    logic [amgt_pkg::DATA_W:0]   w_raise_sum;
    logic [amgt_pkg::DATA_W-1:0] w_raise;
    logic                        w_raise_en;
    assign w_raise_sum = {1'b0, r_item.dens} + {1'b0, i_margin};
    assign w_raise     = w_raise_sum[amgt_pkg::DATA_W] ? '1 : w_raise_sum[amgt_pkg::DATA_W-1:0];
    assign w_raise_en  = (r_state == ST_UPDB) && (r_item.dens > r_rdata);

    // grid memory: one write and one registered read a cycle
    logic                        w_wen;
    logic [AW-1:0]               w_waddr;
    logic [amgt_pkg::DATA_W-1:0] w_wdata;
    assign w_wen   = (r_state == ST_CLEAR) || w_raise_en;
    assign w_waddr = (r_state == ST_CLEAR) ? r_clr : r_addr;
    assign w_wdata = (r_state == ST_CLEAR) ? amgt_pkg::MAJ_RESET : w_raise;

    always_ff @(posedge i_clk) begin
        if (w_wen) begin
            r_grid[w_waddr] <= w_wdata;
        end
        r_rdata <= r_grid[r_addr];
    end

    logic w_emit;
    assign w_emit      = (r_state == ST_EMIT) && (!r_ovalid || i_out_ready);
    assign o_q_ready   = (r_state == ST_IDLE);
    assign o_ready_en  = (r_state != ST_CLEAR);
    assign o_out_valid = r_ovalid;

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= (i_q_item.kind == amgt_pkg::KIND_UPDATE) ? ST_UPDA : ST_FILL;
                    end
                end
                ST_UPDA: r_state <= ST_UPDB;
                ST_UPDB: r_state <= ST_IDLE;
                ST_FILL: begin
                    if (r_cnt[r_ax] != '0) begin
                        r_state <= ST_DIVW;
                    end else if (r_refill || r_ax == 2'd2) begin
                        r_state <= ST_PICK;
                    end
                end
                ST_DIVW: begin
                    if (w_div_done) begin
                        r_state <= (r_refill || r_ax == 2'd2) ? ST_PICK : ST_FILL;
                    end
                end
                ST_PICK: begin
                    if (w_min != amgt_pkg::ONE_Q16 && w_min == r_t0) begin
                        r_state <= ST_FILL;
                    end else begin
                        r_state <= ST_LERP;
                    end
                end
                ST_LERP: begin
                    if (r_step == 4'd8) begin
                        r_state <= ST_MID;
                    end
                end
                ST_MID:  r_state <= ST_RDW;
                ST_RDW:  r_state <= ST_EMIT;
                ST_EMIT: begin
                    if (w_emit) begin
                        r_state <= r_last ? ST_IDLE : ST_FILL;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_item <= i_q_item;
                r_addr <= slot(i_q_item.pa[0], i_q_item.pa[1], i_q_item.pa[2]);
                for (int ax = 0; ax < 3; ax++) begin
                    r_k[ax]   <= i_q_item.ax[ax].k;
                    r_cnt[ax] <= i_q_item.ax[ax].cnt;
                    r_p0[ax]  <= i_q_item.pa[ax];
                end
                r_d0     <= i_q_item.r0;
                r_t0     <= '0;
                r_ax     <= 2'd0;
                r_refill <= 1'b0;
            end
            ST_FILL: begin
                if (r_cnt[r_ax] == '0) begin
                    r_head[r_ax] <= amgt_pkg::ONE_Q16;
                    if (!r_refill && r_ax != 2'd2) begin
                        r_ax <= r_ax + 2'd1;
                    end
                end
            end
            ST_DIVW: begin
                if (w_div_done) begin
                    r_head[r_ax] <= w_quot;
                    r_k[r_ax]    <= r_item.ax[r_ax].dir ? (r_k[r_ax] + 1'b1) : (r_k[r_ax] - 1'b1);
                    r_cnt[r_ax]  <= r_cnt[r_ax] - 1'b1;
                    if (!r_refill && r_ax != 2'd2) begin
                        r_ax <= r_ax + 2'd1;
                    end
                end
            end
            ST_PICK: begin
                r_step <= '0;
                r_sel  <= w_min_ax;
                r_t1   <= w_min;
                r_last <= (w_min == amgt_pkg::ONE_Q16);
                if (w_min != amgt_pkg::ONE_Q16 && w_min == r_t0) begin
                    // zero-length piece: move that axis on
                    r_ax     <= w_min_ax;
                    r_refill <= 1'b1;
                end
            end
            ST_LERP: begin
                r_step <= r_step + 4'd1;
                if (r_step != 4'd8) begin
                    r_prod <= w_op * w_tm;
                end
                if (r_step != 4'd0) begin
                    if (!r_step[0]) begin
                        if (w_pv == 2'd3) begin
                            r_d1 <= w_sum[amgt_pkg::DATA_W+15:16];
                        end else begin
                            r_p1[w_pv] <= w_sum[amgt_pkg::COORD_W+15:16];
                        end
                    end else begin
                        r_acc <= r_prod;
                    end
                end
            end
            ST_MID: begin
                r_addr <= slot(w_mid[0], w_mid[1], w_mid[2]);
            end
            ST_EMIT: begin
                if (w_emit) begin
                    for (int ax = 0; ax < 3; ax++) begin
                        r_p0[ax] <= r_p1[ax];
                    end
                    r_d0     <= r_d1;
                    r_t0     <= r_t1;
                    r_ax     <= r_sel;
                    r_refill <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            o_start_x    <= r_p0[0];
            o_start_y    <= r_p0[1];
            o_start_z    <= r_p0[2];
            o_end_x      <= r_p1[0];
            o_end_y      <= r_p1[1];
            o_end_z      <= r_p1[2];
            o_dist_start <= r_d0;
            o_dist_end   <= r_d1;
            o_majorant   <= r_rdata;
            o_last       <= r_last;
        end
    end

    // checks
    `AMGT_ASSERT_IMP(a_pick_open, i_clk, i_rst_n, r_state == ST_PICK, r_t0 < amgt_pkg::ONE_Q16)
    `AMGT_ASSERT_IMP(a_last_ends, i_clk, i_rst_n, w_emit && r_last, r_t1 == amgt_pkg::ONE_Q16)
    `AMGT_ASSERT_NXT(a_div_wait, i_clk, i_rst_n, w_div_start, r_state == ST_DIVW)
    `AMGT_ASSERT_IMP(a_no_pop_clr, i_clk, i_rst_n, r_state == ST_CLEAR, !o_q_ready && !o_ready_en)

endmodule

`default_nettype wire

>>> rtl/adaptive_majorant_grid_traversal.sv
// ----------------------------------------------------------------------------
// adaptive_majorant_grid_traversal
// Majorant grid with update and voxel-crossing traversal items.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one item per transfer.
//   kind 0 raises a grid entry and returns nothing; kind 1 walks the
//   segment and returns one piece per voxel span on the output channel
//   (o_out_valid / i_out_ready), last_piece high on the final one.
//   Config channel (i_cfg_valid / o_cfg_ready) writes update_margin and is
//   always ready; the user must write it only while the block is idle.
//   An update passes the sequencer states UPDA and UPDB. A traversal
//   runs the shared divider once per plane crossing and, per piece,
//   one 32x17 multiplier over 8 products plus a grid read.
//   After reset a clearing pass writes every grid entry, GRID_DIM^3 of them
//   (4096 at the default); no input item is taken until it ends.
//   A stalled receiver holds one finished piece in the output register; the
//   two-entry queue and the input register keep taking items until full.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_majorant_grid_traversal #(
    parameter int GRID_DIM = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_kind,
    input  wire logic [15:0] i_point_a_x,
    input  wire logic [15:0] i_point_a_y,
    input  wire logic [15:0] i_point_a_z,
    input  wire logic [15:0] i_point_b_x,
    input  wire logic [15:0] i_point_b_y,
    input  wire logic [15:0] i_point_b_z,
    input  wire logic [31:0] i_range_start,
    input  wire logic [31:0] i_range_end,
    input  wire logic [31:0] i_density_sample,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [15:0]      o_piece_start_x,
    output logic [15:0]      o_piece_start_y,
    output logic [15:0]      o_piece_start_z,
    output logic [15:0]      o_piece_end_x,
    output logic [15:0]      o_piece_end_y,
    output logic [15:0]      o_piece_end_z,
    output logic [31:0]      o_piece_dist_start,
    output logic [31:0]      o_piece_dist_end,
    output logic [31:0]      o_piece_majorant,
    output logic             o_last_piece
);

    logic [31:0]     r_margin;
    logic            w_en;
    logic            w_f_valid;
    logic            w_f_ready;
    amgt_pkg::t_item w_f_item;
    logic            w_q_valid;
    logic            w_q_ready;
    amgt_pkg::t_item w_q_item;

    // margin register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= amgt_pkg::MARGIN_RESET;
        end else if (i_cfg_valid) begin
            r_margin <= i_cfg_data;
        end
    end

    amgt_front #(
        .GRID_DIM (GRID_DIM)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_kind  (i_kind),
        .i_pa    ({i_point_a_z, i_point_a_y, i_point_a_x}),
        .i_pb    ({i_point_b_z, i_point_b_y, i_point_b_x}),
        .i_r0    (i_range_start),
        .i_r1    (i_range_end),
        .i_dens  (i_density_sample),
        .o_valid (w_f_valid),
        .o_item  (w_f_item),
        .i_ready (w_f_ready)
    );

    amgt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_item  (w_f_item),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_ready (w_q_ready)
    );

    amgt_back #(
        .GRID_DIM (GRID_DIM)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_margin     (r_margin),
        .o_ready_en   (w_en),
        .i_q_valid    (w_q_valid),
        .o_q_ready    (w_q_ready),
        .i_q_item     (w_q_item),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_start_x    (o_piece_start_x),
        .o_start_y    (o_piece_start_y),
        .o_start_z    (o_piece_start_z),
        .o_end_x      (o_piece_end_x),
        .o_end_y      (o_piece_end_y),
        .o_end_z      (o_piece_end_z),
        .o_dist_start (o_piece_dist_start),
        .o_dist_end   (o_piece_dist_end),
        .o_majorant   (o_piece_majorant),
        .o_last       (o_last_piece)
    );

endmodule

`default_nettype wire

>>> tb/sv/adaptive_majorant_grid_traversal_tb.sv
// ----------------------------------------------------------------------------
// adaptive_majorant_grid_traversal_tb
// Self-checking bench for the majorant grid traversal block. Update and
// traversal items are sent under random bursts and gaps while the receiver
// stalls on its own pattern. A behavioural copy of the grid predicts every
// piece, and each piece is checked field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_majorant_grid_traversal_tb;

    localparam int GD          = 16;
    localparam int GRID_CELLS  = GD * GD * GD;
    localparam int IDLE_WAIT   = 60;      // covers an update still in flight
    localparam int HOLD_CYCLES = 3000;
    localparam int WD_LIMIT    = 40000;   // clearing pass plus long stall, with margin
    localparam int RAND_ITEMS  = 430;

    typedef struct packed {
        logic [15:0] sx, sy, sz, ex, ey, ez;
        logic [31:0] dist_s, dist_e, maj;
        logic        last;
    } t_piece;

    typedef struct packed {
        logic        kind;
        logic [15:0] ax, ay, az, bx, by, bz;
        logic [31:0] r0, r1, dens;
    } t_grid_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_kind = amgt_pkg::KIND_UPDATE;
    logic [15:0] i_point_a_x = '0, i_point_a_y = '0, i_point_a_z = '0;
    logic [15:0] i_point_b_x = '0, i_point_b_y = '0, i_point_b_z = '0;
    logic [31:0] i_range_start = '0, i_range_end = '0, i_density_sample = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_piece_start_x, o_piece_start_y, o_piece_start_z;
    logic [15:0] o_piece_end_x, o_piece_end_y, o_piece_end_z;
    logic [31:0] o_piece_dist_start, o_piece_dist_end, o_piece_majorant;
    logic        o_last_piece;

    // predictor state
    logic [31:0] maj_grid [GRID_CELLS];
    logic [31:0] margin_q;
    t_piece      pending_pieces[$];
    int          err_count = 0;

    // sender pacing
    int          burst_left = 0;
    bit          gapless = 1'b0;

    // receiver hold-off request (toggle) and pattern
    bit          hold_tog = 1'b0, hold_seen = 1'b0;
    int          hold_left = 0;
    int          rx_mode = 0, rx_mode_left = 0;

    int          idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    adaptive_majorant_grid_traversal #(.GRID_DIM(GD)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_kind(i_kind),
        .i_point_a_x(i_point_a_x), .i_point_a_y(i_point_a_y), .i_point_a_z(i_point_a_z),
        .i_point_b_x(i_point_b_x), .i_point_b_y(i_point_b_y), .i_point_b_z(i_point_b_z),
        .i_range_start(i_range_start), .i_range_end(i_range_end),
        .i_density_sample(i_density_sample),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_piece_start_x(o_piece_start_x), .o_piece_start_y(o_piece_start_y),
        .o_piece_start_z(o_piece_start_z), .o_piece_end_x(o_piece_end_x),
        .o_piece_end_y(o_piece_end_y), .o_piece_end_z(o_piece_end_z),
        .o_piece_dist_start(o_piece_dist_start), .o_piece_dist_end(o_piece_dist_end),
        .o_piece_majorant(o_piece_majorant), .o_last_piece(o_last_piece)
    );

    // ------------------------------------------------------------------
    // Grid predictor
    // ------------------------------------------------------------------
    function automatic int unsigned voxel_index(input logic [31:0] c);
        int unsigned v;
        v = (c * GD) >> 16;
        if (v > GD - 1) v = GD - 1;
        return v;
    endfunction

    function automatic int unsigned cell_addr(input logic [31:0] x, y, z);
        return (voxel_index(z) * GD + voxel_index(y)) * GD + voxel_index(x);
    endfunction

    function automatic logic [31:0] lerp_q16(input logic [31:0] a, b,
                                             input longint unsigned t);
        longint unsigned s;
        s = longint'(a) * (65536 - t) + longint'(b) * t;
        return s[47:16];
    endfunction

    // plane crossings of one axis, parameter strictly inside (0,1)
    function automatic void axis_crossings(input logic [15:0] a, b,
                                           ref longint unsigned ts[$]);
        longint unsigned va, vb, ia, ib, num, den, t;
        va = a * GD;
        vb = b * GD;
        ia = va >> 16;
        ib = vb >> 16;
        if (ib > ia) begin
            den = vb - va;
            for (longint unsigned k = ia + 1; k <= ib; k++) begin
                num = (k << 16) - va;
                t = (num << 16) / den;
                if (t > 0 && t < 65536) ts = {ts, t};
            end
        end else if (ib < ia) begin
            den = va - vb;
            for (longint unsigned k = ia; k > ib; k--) begin
                num = va - (k << 16);
                t = (num << 16) / den;
                if (t > 0 && t < 65536) ts = {ts, t};
            end
        end
    endfunction

    function automatic void predict_item(input t_grid_item it);
        longint unsigned ts[$];
        longint unsigned raised;
        int unsigned     slot;
        t_piece          p;
        logic [15:0]     s [3];
        logic [15:0]     e [3];
        logic [15:0]     pa [3];
        logic [15:0]     pb [3];
        int              first;
        if (it.kind == amgt_pkg::KIND_UPDATE) begin
            slot = cell_addr(it.ax, it.ay, it.az);
            if (it.dens > maj_grid[slot]) begin
                raised = longint'(it.dens) + margin_q;
                maj_grid[slot] = (raised > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : raised[31:0];
            end
            return;
        end
        pa = '{it.ax, it.ay, it.az};
        pb = '{it.bx, it.by, it.bz};
        ts = {ts, 64'd0};
        for (int a = 0; a < 3; a++) axis_crossings(pa[a], pb[a], ts);
        ts = {ts, 64'd65536};
        ts.sort();
        first = pending_pieces.size();
        for (int i = 0; i + 1 < ts.size(); i++) begin
            if (ts[i] >= 65536 || ts[i] == ts[i+1]) continue;
            for (int a = 0; a < 3; a++) begin
                s[a] = 16'(lerp_q16(pa[a], pb[a], ts[i]));
                e[a] = 16'(lerp_q16(pa[a], pb[a], ts[i+1]));
            end
            p.sx = s[0]; p.sy = s[1]; p.sz = s[2];
            p.ex = e[0]; p.ey = e[1]; p.ez = e[2];
            p.dist_s = lerp_q16(it.r0, it.r1, ts[i]);
            p.dist_e = lerp_q16(it.r0, it.r1, ts[i+1]);
            p.maj = maj_grid[cell_addr((s[0] + 17'(e[0])) >> 1,
                                       (s[1] + 17'(e[1])) >> 1,
                                       (s[2] + 17'(e[2])) >> 1)];
            p.last = 1'b0;
            pending_pieces = {pending_pieces, p};
        end
        if (pending_pieces.size() > first) pending_pieces[$].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Shared stimulus tasks
    // ------------------------------------------------------------------
    task automatic send_item(input t_grid_item it);
        int gap;
        if (!gapless && burst_left == 0) begin
            gap = $urandom_range(0, 14);
            burst_left = $urandom_range(1, 10);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left != 0) burst_left--;
        i_in_valid       <= 1'b1;
        i_kind           <= it.kind;
        i_point_a_x      <= it.ax;
        i_point_a_y      <= it.ay;
        i_point_a_z      <= it.az;
        i_point_b_x      <= it.bx;
        i_point_b_y      <= it.by;
        i_point_b_z      <= it.bz;
        i_range_start    <= it.r0;
        i_range_end      <= it.r1;
        i_density_sample <= it.dens;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_item(it);
    endtask

    task automatic drain_pieces();
        i_in_valid <= 1'b0;
        while (pending_pieces.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_margin(input logic [31:0] value);
        drain_pieces();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        margin_q = value;
    endtask

    function automatic t_grid_item update_at(input logic [15:0] x, y, z,
                                             input logic [31:0] dens);
        t_grid_item it;
        it = '{default: '0};
        it.kind = amgt_pkg::KIND_UPDATE;
        it.ax = x; it.ay = y; it.az = z;
        it.dens = dens;
        return it;
    endfunction

    function automatic t_grid_item segment(input logic [15:0] ax, ay, az, bx, by, bz,
                                           input logic [31:0] r0, r1);
        t_grid_item it;
        it = '{kind: amgt_pkg::KIND_TRAVERSE, ax: ax, ay: ay, az: az,
               bx: bx, by: by, bz: bz, r0: r0, r1: r1, dens: $urandom};
        return it;
    endfunction

    // mostly short hops so items stay cheap, now and then a long one
    function automatic logic [15:0] near_coord(input logic [15:0] c);
        if ($urandom_range(0, 5) == 0) return 16'($urandom);
        return c + 16'($urandom_range(0, 8191)) - 16'd4096;
    endfunction

    function automatic t_grid_item random_item();
        t_grid_item it;
        it.kind = ($urandom_range(0, 9) < 4) ? amgt_pkg::KIND_UPDATE : amgt_pkg::KIND_TRAVERSE;
        it.ax = $urandom; it.ay = $urandom; it.az = $urandom;
        it.bx = near_coord(it.ax);
        it.by = near_coord(it.ay);
        it.bz = near_coord(it.az);
        it.r0 = $urandom;
        it.r1 = ($urandom_range(0, 3) == 0) ? $urandom : it.r0 + $urandom_range(0, 1 << 20);
        case ($urandom_range(0, 3))
            0: it.dens = $urandom_range(0, 2000);
            1: it.dens = $urandom;
            default: it.dens = $urandom_range(0, 1 << 20);
        endcase
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_field_extremes();
        // grid corners, no-raise and saturating raises
        send_item(update_at(16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF));
        send_item(update_at(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd0));
        send_item(update_at(16'hFFFF, 16'h0000, 16'hFFFF, 32'd655));
        send_item(update_at(16'h0FFF, 16'hF000, 16'h8000, 32'd656));
        send_item(update_at(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFF0));
        // full diagonal: duplicate crossings on all three axes
        send_item(segment(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          32'd0, 32'hFFFF_FFFF));
        // same diagonal backwards with a reversed range
        send_item(segment(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
                          32'hFFFF_FFFF, 32'd0));
        // degenerate segment: one piece
        send_item(segment(16'h1234, 16'h5678, 16'h9ABC, 16'h1234, 16'h5678, 16'h9ABC,
                          32'h0001_0000, 32'h0002_0000));
        // axis-aligned segments (the first with endpoints on planes), then a short diagonal with endpoints on planes
        send_item(segment(16'h1000, 16'h8000, 16'h8000, 16'hF000, 16'h8000, 16'h8000,
                          32'd100, 32'd100));
        send_item(segment(16'h8000, 16'h0000, 16'h4000, 16'h8000, 16'hFFFF, 16'h4000,
                          32'hAAAA_AAAA, 32'h5555_5555));
        send_item(segment(16'h4321, 16'h4321, 16'h0001, 16'h4321, 16'h4321, 16'hFFFE,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(segment(16'h0FFF, 16'h1000, 16'h2FFF, 16'h1000, 16'h0FFF, 16'h3000,
                          32'd0, 32'd1));
    endtask

    task automatic test_margin_settings();
        write_margin(32'd0);
        send_item(update_at(16'h2000, 16'h2000, 16'h2000, 32'd700));
        send_item(segment(16'h2100, 16'h2100, 16'h2100, 16'h3000, 16'h2800, 16'h2200,
                          32'd0, 32'h0010_0000));
        write_margin(32'hFFFF_FFFF);
        send_item(update_at(16'h3000, 16'h3000, 16'h3000, 32'd1000));
        send_item(update_at(16'h3000, 16'h3000, 16'h3000, 32'd1));
        send_item(segment(16'h2F00, 16'h3100, 16'h3100, 16'h3100, 16'h2F00, 16'h3100,
                          32'd5, 32'd9));
        write_margin(32'h5A5A_A5A5);
        send_item(update_at(16'h7000, 16'h9000, 16'hB000, 32'h0000_8000));
        send_item(segment(16'h6000, 16'h9000, 16'hB000, 16'h8000, 16'h9000, 16'hB000,
                          32'd0, 32'd65536));
        write_margin(amgt_pkg::MARGIN_RESET);
    endtask

    task automatic test_output_backpressure();
        drain_pieces();
        hold_tog = ~hold_tog;
        gapless = 1'b1;
        for (int i = 0; i < 12; i++) begin
            t_grid_item it;
            it = random_item();
            it.kind = amgt_pkg::KIND_TRAVERSE;
            send_item(it);
        end
        gapless = 1'b0;
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i % 100 == 99) begin
                case ((i / 100) % 3)
                    0: write_margin($urandom);
                    1: write_margin($urandom_range(0, 1 << 16));
                    default: write_margin(32'hFFFF_FFFF);
                endcase
            end
            send_item(random_item());
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall pattern, plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_tog != hold_seen) begin
            hold_seen   <= hold_tog;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= $urandom_range(0, 3);
                rx_mode_left <= $urandom_range(20, 200);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= $urandom_range(0, 1);
                2: i_out_ready <= ($urandom_range(0, 9) == 0);
                default: i_out_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got, exp_v);
        $display("mismatch %s: got %0h, expected %0h at %0t", what, got, exp_v, $time);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_piece want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_pieces.size() == 0) begin
                report_mismatch("unexpected piece", o_piece_majorant, 32'd0);
            end else begin
                want = pending_pieces.pop_front();
                if (o_piece_start_x !== want.sx) report_mismatch("start_x", o_piece_start_x, want.sx);
                if (o_piece_start_y !== want.sy) report_mismatch("start_y", o_piece_start_y, want.sy);
                if (o_piece_start_z !== want.sz) report_mismatch("start_z", o_piece_start_z, want.sz);
                if (o_piece_end_x !== want.ex) report_mismatch("end_x", o_piece_end_x, want.ex);
                if (o_piece_end_y !== want.ey) report_mismatch("end_y", o_piece_end_y, want.ey);
                if (o_piece_end_z !== want.ez) report_mismatch("end_z", o_piece_end_z, want.ez);
                if (o_piece_dist_start !== want.dist_s)
                    report_mismatch("dist_start", o_piece_dist_start, want.dist_s);
                if (o_piece_dist_end !== want.dist_e)
                    report_mismatch("dist_end", o_piece_dist_end, want.dist_e);
                if (o_piece_majorant !== want.maj)
                    report_mismatch("majorant", o_piece_majorant, want.maj);
                if (o_last_piece !== want.last)
                    report_mismatch("last_piece", o_last_piece, want.last);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WD_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < GRID_CELLS; i++) maj_grid[i] = amgt_pkg::MAJ_RESET;
        margin_q = amgt_pkg::MARGIN_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_field_extremes();
        test_margin_settings();
        test_output_backpressure();
        test_random_traffic();
        drain_pieces();
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
